@@ rtl/core/length_prefixed_record_skipper_macros.svh @@
// Assertion macros shared by the record skipper RTL.
`ifndef LENGTH_PREFIXED_RECORD_SKIPPER_MACROS_SVH
`define LENGTH_PREFIXED_RECORD_SKIPPER_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define LPRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LPRS_ASSERT_NEXT(label, ante, cons, msg) \
  `LPRS_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ rtl/core/lprs_pkg.sv @@
// Types and constants shared by the record skipper modules.
`default_nettype none

package lprs_pkg;

  localparam int unsigned LPRS_DATA_W  = 32;
  localparam int unsigned LPRS_ADDR_W  = 3;
  localparam int unsigned LPRS_Q_DEPTH = 4;

  localparam logic LPRS_REG_SKIP_COUNT = 1'b0;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_SKIP,
    PH_PASS,
    PH_ERR
  } lprs_phase_t;

  typedef enum logic [2:0] {
    ST_DONE,
    ST_EARLY,
    ST_TRUNC_LEN,
    ST_BAD_SIZE,
    ST_TRUNC_DOC
  } lprs_status_t;

  // One queued result: data holds the byte, or the status code for a status.
  typedef struct packed {
    logic        is_status;
    logic [7:0]  data;
    logic [31:0] count;
    logic        last;
  } lprs_res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lprs_qstat_t;

endpackage

`default_nettype wire

@@ rtl/core/lprs_if.sv @@
// Stream interfaces for the input byte channel and the result channel.
`default_nettype none

interface lprs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface lprs_out_if;
  logic        valid;
  logic        ready;
  logic        is_status;
  logic [7:0]  out_byte;
  logic [2:0]  status_code;
  logic [31:0] docs_skipped;
  logic        out_last;

  modport source (output valid, output is_status, output out_byte, output status_code,
                  output docs_skipped, output out_last, input ready);
  modport sink (input valid, input is_status, input out_byte, input status_code,
                input docs_skipped, input out_last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lprs_front.sv @@
// Front end: accepts stream beats, tracks document framing and queues results.
`default_nettype none

module lprs_front
  import lprs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] skip_count,
  lprs_in_if.sink     in_s,
  input  lprs_qstat_t qstat,
  output logic        push,
  output lprs_res_t   push_data
);

  lprs_phase_t phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [23:0] word_r, word_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] skipped_r, skipped_nxt;

  logic        fire;
  logic        at_start;
  logic [31:0] full_len;
  logic [31:0] skipped_inc;
  lprs_status_t end_code;

  assign in_s.ready  = !qstat.full;
  assign fire        = in_s.valid && in_s.ready;
  assign at_start    = (idx_r == 2'd0) && (skipped_r >= skip_count);
  assign full_len    = {in_s.in_byte, word_r};
  assign skipped_inc = skipped_r + 32'd1;
  assign end_code    = (skipped_inc < skip_count) ? ST_EARLY : ST_DONE;

  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      if (in_s.in_last) begin
        phase_nxt = PH_LEN;
      end else begin
        case (phase_r)
          PH_LEN: begin
            if (at_start) begin
              phase_nxt = PH_PASS;
            end else if (idx_r == 2'd3) begin
              if (full_len < 32'd4) begin
                phase_nxt = PH_ERR;
              end else if (full_len == 32'd4) begin
                phase_nxt = PH_LEN;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            if (rem_r == 32'd1) begin
              phase_nxt = PH_LEN;
            end
          end
          PH_PASS: phase_nxt = PH_PASS;
          PH_ERR:  phase_nxt = PH_ERR;
          default: phase_nxt = PH_LEN;
        endcase
      end
    end
  end

  always_comb begin
    idx_nxt             = idx_r;
    word_nxt            = word_r;
    rem_nxt             = rem_r;
    skipped_nxt         = skipped_r;
    push                = 1'b0;
    push_data.is_status = 1'b0;
    push_data.data      = in_s.in_byte;
    push_data.count     = skipped_r;
    push_data.last      = in_s.in_last;
    if (fire) begin
      case (phase_r)
        PH_LEN: begin
          if (at_start) begin
            push = 1'b1;
          end else begin
            case (idx_r)
              2'd0:    word_nxt[7:0]   = in_s.in_byte;
              2'd1:    word_nxt[15:8]  = in_s.in_byte;
              2'd2:    word_nxt[23:16] = in_s.in_byte;
              default: word_nxt        = word_r;
            endcase
            idx_nxt = idx_r + 2'd1;
            if (idx_r != 2'd3) begin
              if (in_s.in_last) begin
                push                = 1'b1;
                push_data.is_status = 1'b1;
                push_data.data      = {5'd0, ST_TRUNC_LEN};
              end
            end else if (full_len < 32'd4) begin
              push                = 1'b1;
              push_data.is_status = 1'b1;
              push_data.data      = {5'd0, ST_BAD_SIZE};
            end else if (full_len == 32'd4) begin
              skipped_nxt = skipped_inc;
              if (in_s.in_last) begin
                push                = 1'b1;
                push_data.is_status = 1'b1;
                push_data.data      = {5'd0, end_code};
                push_data.count     = skipped_inc;
              end
            end else begin
              rem_nxt = full_len - 32'd4;
              if (in_s.in_last) begin
                push                = 1'b1;
                push_data.is_status = 1'b1;
                push_data.data      = {5'd0, ST_TRUNC_DOC};
              end
            end
          end
        end
        PH_SKIP: begin
          if (rem_r == 32'd1) begin
            skipped_nxt = skipped_inc;
            idx_nxt     = 2'd0;
            if (in_s.in_last) begin
              push                = 1'b1;
              push_data.is_status = 1'b1;
              push_data.data      = {5'd0, end_code};
              push_data.count     = skipped_inc;
            end
          end else begin
            rem_nxt = rem_r - 32'd1;
            if (in_s.in_last) begin
              push                = 1'b1;
              push_data.is_status = 1'b1;
              push_data.data      = {5'd0, ST_TRUNC_DOC};
            end
          end
        end
        PH_PASS: begin
          push = 1'b1;
        end
        PH_ERR: begin
          push = 1'b0;
        end
        default: begin
          push = 1'b0;
        end
      endcase
      if (in_s.in_last) begin
        idx_nxt     = 2'd0;
        rem_nxt     = 32'd0;
        skipped_nxt = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEN;
      idx_r     <= 2'd0;
      skipped_r <= 32'd0;
    end else begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      skipped_r <= skipped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    rem_r  <= rem_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/core/lprs_queue.sv @@
// Short result queue between the framing front end and the output stage.
`default_nettype none

module lprs_queue
  import lprs_pkg::*;
#(
  parameter int unsigned DEPTH = LPRS_Q_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  lprs_res_t   push_data,
  input  logic        pop,
  output lprs_res_t   head,
  output lprs_qstat_t qstat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lprs_res_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign qstat.full  = (cnt_r == CNT_W'(DEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign head        = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lprs_back.sv @@
// Back end: formats queued results into the registered output channel.
`default_nettype none

module lprs_back
  import lprs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  lprs_qstat_t qstat,
  input  lprs_res_t   head,
  output logic        pop,
  lprs_out_if.source  out_m
);

  logic        valid_r;
  logic        is_status_r;
  logic [7:0]  byte_r;
  logic [2:0]  code_r;
  logic [31:0] count_r;
  logic        last_r;

  assign pop = !qstat.empty && (!valid_r || out_m.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_m.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      is_status_r <= head.is_status;
      byte_r      <= head.is_status ? 8'd0 : head.data;
      code_r      <= head.is_status ? head.data[2:0] : 3'd0;
      count_r     <= head.is_status ? head.count : 32'd0;
      last_r      <= head.last;
    end
  end

  assign out_m.valid        = valid_r;
  assign out_m.is_status    = is_status_r;
  assign out_m.out_byte     = byte_r;
  assign out_m.status_code  = code_r;
  assign out_m.docs_skipped = count_r;
  assign out_m.out_last     = last_r;

endmodule

`default_nettype wire

@@ rtl/core/length_prefixed_record_skipper.sv @@
// Top level of the length-prefixed record skipper with its register port.
`default_nettype none
`include "length_prefixed_record_skipper_macros.svh"

// The block takes one stream byte per cycle while its result queue is not
// full, drops the first skip_count length-prefixed documents and passes
// every later byte through. It gives one status beat when the stream ends
// before passthrough begins, or on a framing error. The framing front end
// updates its length and count registers for each accepted byte. Results
// pass through a queue of Q_DEPTH entries and then a registered output
// stage, and in_s.ready drops only while the queue is full.
module length_prefixed_record_skipper
  import lprs_pkg::*;
#(
  parameter int unsigned Q_DEPTH = LPRS_Q_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [LPRS_ADDR_W-1:0] paddr,
  input  logic [LPRS_DATA_W-1:0] pwdata,
  output logic [LPRS_DATA_W-1:0] prdata,
  output logic                   pready,
  lprs_in_if.sink                in_s,
  lprs_out_if.source             out_m
);

  logic [31:0] skip_count_r;
  logic        cfg_wr;
  logic        push;
  logic        pop;
  lprs_res_t   push_data;
  lprs_res_t   head;
  lprs_qstat_t qstat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == LPRS_REG_SKIP_COUNT);
  assign prdata = (paddr[2] == LPRS_REG_SKIP_COUNT) ? skip_count_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_count_r <= 32'd0;
    end else if (cfg_wr) begin
      skip_count_r <= pwdata;
    end
  end

  lprs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .skip_count (skip_count_r),
    .in_s       (in_s),
    .qstat      (qstat),
    .push       (push),
    .push_data  (push_data)
  );

  lprs_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  lprs_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .qstat (qstat),
    .head  (head),
    .pop   (pop),
    .out_m (out_m)
  );

  `LPRS_ASSERT(a_queue_state, !(qstat.full && qstat.empty), "queue both full and empty")
  `LPRS_ASSERT(a_data_fields, !(out_m.valid && !out_m.is_status) || (out_m.status_code == 3'd0 && out_m.docs_skipped == 32'd0), "data beat carries status fields")
  `LPRS_ASSERT(a_idle_latency, (push && qstat.empty && !out_m.valid) |-> ##2 out_m.valid, "result did not reach an idle output")
  `LPRS_ASSERT_NEXT(a_cfg_write, cfg_wr, skip_count_r == $past(pwdata), "skip_count write lost")

endmodule

`default_nettype wire

@@ bench/length_prefixed_record_skipper_tb.sv @@
// Self-checking testbench for the length-prefixed record skipper.
`default_nettype none

module length_prefixed_record_skipper_tb
  import lprs_pkg::*;
();

  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned HOLD_BYTES = 64;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [LPRS_ADDR_W-1:0] SKIP_COUNT_ADDR = LPRS_ADDR_W'(4 * LPRS_REG_SKIP_COUNT);

  typedef struct {
    logic         is_status;
    logic [7:0]   out_byte;
    lprs_status_t status_code;
    logic [31:0]  docs_skipped;
    logic         out_last;
  } skip_beat_t;

  class record_skip_checker;
    lprs_phase_t phase;
    logic [1:0]  len_idx;
    logic [31:0] len_word;
    logic [31:0] body_left;
    logic [31:0] docs_done;
    logic [31:0] skip_target;
    skip_beat_t  pending_results[$];
    int          errors;

    function new();
      skip_target = '0;
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase = PH_LEN;
      len_idx = '0;
      len_word = '0;
      body_left = '0;
      docs_done = '0;
    endfunction

    function void set_skip(logic [31:0] value);
      skip_target = value;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void add_data(logic [7:0] b, logic last);
      skip_beat_t r;
      r.is_status = 1'b0;
      r.out_byte = b;
      r.status_code = ST_DONE;
      r.docs_skipped = '0;
      r.out_last = last;
      pending_results.push_back(r);
    endfunction

    function void add_status(lprs_status_t code, logic last);
      skip_beat_t r;
      r.is_status = 1'b1;
      r.out_byte = '0;
      r.status_code = code;
      r.docs_skipped = docs_done;
      r.out_last = last;
      pending_results.push_back(r);
    endfunction

    function void finish_doc(logic last);
      docs_done = docs_done + 1;
      phase = PH_LEN;
      len_idx = '0;
      len_word = '0;
      body_left = '0;
      if (last) begin
        add_status((docs_done < skip_target) ? ST_EARLY : ST_DONE, 1'b1);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      case (phase)
        PH_LEN: begin
          if (len_idx == 2'd0 && docs_done >= skip_target) begin
            add_data(b, last);
            phase = PH_PASS;
          end else begin
            len_word = len_word | (32'(b) << (len_idx * 8));
            len_idx = len_idx + 2'd1;
            if (len_idx != 2'd0) begin
              if (last) begin
                add_status(ST_TRUNC_LEN, 1'b1);
              end
            end else if (len_word < 32'd4) begin
              add_status(ST_BAD_SIZE, last);
              phase = PH_ERR;
            end else begin
              body_left = len_word - 32'd4;
              if (body_left == '0) begin
                finish_doc(last);
              end else begin
                phase = PH_SKIP;
                if (last) begin
                  add_status(ST_TRUNC_DOC, 1'b1);
                end
              end
            end
          end
        end
        PH_SKIP: begin
          body_left = body_left - 32'd1;
          if (body_left == '0) begin
            finish_doc(last);
          end else if (last) begin
            add_status(ST_TRUNC_DOC, 1'b1);
          end
        end
        PH_PASS: begin
          add_data(b, last);
        end
        default: begin
        end
      endcase
      if (last) begin
        restart();
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 200) begin
        $display("mismatch: %s", what);
      end
    endtask

    task check_beat(logic is_status, logic [7:0] ob, logic [2:0] sc, logic [31:0] ds,
                    logic ol);
      skip_beat_t e;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (status %0b byte %02h)",
                                  is_status, ob));
      end else begin
        e = pending_results.pop_front();
        if (is_status !== e.is_status)
          report_mismatch($sformatf("is_status %b, expected %b", is_status, e.is_status));
        if (ob !== e.out_byte)
          report_mismatch($sformatf("out_byte %02h, expected %02h", ob, e.out_byte));
        if (sc !== e.status_code)
          report_mismatch($sformatf("status_code %0d, expected %0d", sc, e.status_code));
        if (ds !== e.docs_skipped)
          report_mismatch($sformatf("docs_skipped %0d, expected %0d", ds, e.docs_skipped));
        if (ol !== e.out_last)
          report_mismatch($sformatf("out_last %b, expected %b", ol, e.out_last));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [LPRS_ADDR_W-1:0] paddr;
  logic [LPRS_DATA_W-1:0] pwdata;
  logic [LPRS_DATA_W-1:0] prdata;
  logic pready;

  lprs_in_if in_ch();
  lprs_out_if out_ch();

  record_skip_checker sb = new();
  logic [7:0] stream_q[$];
  int unsigned bytes_sent;
  logic [31:0] cur_skip;
  bit send_burst;
  bit hold_go;
  int unsigned idle_cycles;

  length_prefixed_record_skipper dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_s   (in_ch),
    .out_m  (out_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task send_stream();
    int gap;
    for (int i = 0; i < stream_q.size(); i++) begin
      gap = send_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.in_byte <= stream_q[i];
      in_ch.in_last <= (i == stream_q.size() - 1);
      do @(posedge clk); while (!(in_ch.valid && in_ch.ready === 1'b1));
      sb.note_byte(in_ch.in_byte, in_ch.in_last);
      bytes_sent++;
    end
    stream_q.delete();
  endtask

  task wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_skip_count(logic [31:0] value);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SKIP_COUNT_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_skip(value);
    cur_skip = value;
  endtask

  function void push_word(logic [31:0] w);
    for (int k = 0; k < 4; k++) stream_q.push_back(w[8*k +: 8]);
  endfunction

  function void push_random(int n);
    for (int k = 0; k < n; k++) stream_q.push_back(8'($urandom));
  endfunction

  function void push_docs(int n);
    int len;
    for (int d = 0; d < n; d++) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 300) : $urandom_range(4, 12);
      push_word(32'(len));
      push_random(len - 4);
    end
  endfunction

  function logic [31:0] pick_skip();
    case ($urandom_range(0, 9))
      0: return 32'hFFFF_FFFF;
      1: return 32'($urandom);
      2: return 32'd0;
      default: return 32'($urandom_range(0, 4));
    endcase
  endfunction

  task random_stream();
    int kind;
    int ndocs;
    int len;
    kind = $urandom_range(0, 9);
    ndocs = (cur_skip <= 4 && $urandom_range(0, 3) != 0) ? int'(cur_skip) : $urandom_range(0, 4);
    if (kind != 9) push_docs(ndocs);
    case (kind)
      6: push_random($urandom_range(1, 3));
      7: begin
        push_word(32'($urandom_range(0, 3)));
        push_random($urandom_range(0, 5));
      end
      8: begin
        if ($urandom_range(0, 3) == 0) begin
          push_word(32'($urandom) | 32'h8000_0000);
          push_random($urandom_range(0, 3));
        end else begin
          len = $urandom_range(5, 40);
          push_word(32'(len));
          push_random($urandom_range(0, len - 5));
        end
      end
      9: push_random($urandom_range(1, 16));
      default: push_random($urandom_range(0, 24));
    endcase
    if (stream_q.size() == 0) push_random(1);
    send_stream();
  endtask

  initial begin : result_sink
    int gap;
    bit burst;
    bit held;
    burst = 1'b0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held && hold_go) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if ($urandom_range(0, 15) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready));
      sb.check_beat(out_ch.is_status, out_ch.out_byte, out_ch.status_code,
                    out_ch.docs_skipped, out_ch.out_last);
    end
  end

  initial begin : stimulus
    int streams;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.in_last <= 1'b0;
    idle_cycles = 0;
    bytes_sent = 0;
    cur_skip = '0;
    send_burst = 1'b0;
    hold_go = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_skip_count(32'd0);
    stream_q = '{8'h00, 8'hFF};
    send_stream();
    write_skip_count(32'd1);
    stream_q = '{8'h04, 8'h00, 8'h00, 8'h00};
    send_stream();
    write_skip_count(32'd2);
    stream_q = '{8'h05, 8'h00, 8'h00, 8'h00, 8'hAA};
    send_stream();
    stream_q = '{8'h06, 8'h00};
    send_stream();
    stream_q = '{8'h02, 8'h00, 8'h00, 8'h00, 8'h11, 8'h22};
    send_stream();
    stream_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01};
    send_stream();
    write_skip_count(32'hFFFF_FFFF);

    streams = 0;
    while (bytes_sent + HOLD_BYTES < RANDOM_ITEMS) begin
      if (streams > 0 && $urandom_range(0, 5) == 0) write_skip_count(pick_skip());
      send_burst = ($urandom_range(0, 3) == 0);
      random_stream();
      streams++;
    end

    // A long passthrough stream sent while the receiver holds off fills the block.
    write_skip_count(32'd0);
    hold_go = 1'b1;
    send_burst = 1'b1;
    push_random(int'(HOLD_BYTES));
    send_stream();
    send_burst = 1'b0;
    stream_q = '{8'h7F, 8'h80};
    send_stream();

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("expected results left over at the end");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl/core
rtl/core/lprs_pkg.sv
rtl/core/lprs_if.sv
rtl/core/lprs_front.sv
rtl/core/lprs_queue.sv
rtl/core/lprs_back.sv
rtl/core/length_prefixed_record_skipper.sv
bench/length_prefixed_record_skipper_tb.sv
